// File: design/vwft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwft_pkg
// Shared sizes and types of the vertex weld and triangle fan block.
// ----------------------------------------------------------------------------
package vwft_pkg;

  localparam int VERTEX_DEPTH = 1024;
  localparam int FACE_DEPTH   = 64;
  localparam int TEXTURE_BITS = 16;

  localparam int KEY_BITS = 160;
  localparam int VW       = $clog2(VERTEX_DEPTH);
  localparam int FW       = (FACE_DEPTH > 1) ? $clog2(FACE_DEPTH) : 1;
  localparam int GROUP    = 32;
  localparam int GROUPS   = (VERTEX_DEPTH + GROUP - 1) / GROUP;

  localparam int IN_BITS  = 176;
  localparam int OUT_BITS = 48;

  typedef logic [KEY_BITS-1:0]     key_t;
  typedef logic [VW-1:0]           vidx_t;
  typedef logic [VW:0]             vfill_t;
  typedef logic [FW-1:0]           fidx_t;
  typedef logic [FW:0]             ffill_t;
  typedef logic [TEXTURE_BITS-1:0] tex_t;

  typedef struct packed {
    logic  en;
    vidx_t addr;
  } vwr_t;

  typedef struct packed {
    logic  en;
    fidx_t addr;
  } fwr_t;

endpackage

// File: design/vwft_vcell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwft_vcell
// One vertex table entry: holds a key and flags a match with the probe key.
// ----------------------------------------------------------------------------
module vwft_vcell (
  input  logic            clk,
  input  vwft_pkg::vidx_t index,
  input  vwft_pkg::vfill_t fill,
  input  vwft_pkg::key_t  probe,
  input  vwft_pkg::vwr_t  wr,
  output logic            match
);

  vwft_pkg::key_t key;

  always_ff @(posedge clk) begin
    if (wr.en && wr.addr == index) begin
      key <= probe;
    end
    match <= ({1'b0, index} < fill) && (key == probe);
  end

endmodule

// File: design/vwft_fcell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwft_fcell
// One face table entry: holds a texture id and flags a match with the probe.
// ----------------------------------------------------------------------------
module vwft_fcell (
  input  logic             clk,
  input  vwft_pkg::fidx_t  index,
  input  vwft_pkg::ffill_t fill,
  input  vwft_pkg::tex_t   probe,
  input  vwft_pkg::fwr_t   wr,
  output logic             match
);

  vwft_pkg::tex_t tex;

  always_ff @(posedge clk) begin
    if (wr.en && wr.addr == index) begin
      tex <= probe;
    end
    match <= ({1'b0, index} < fill) && (tex == probe);
  end

endmodule

// File: design/vertex_weld_fan_triangulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_weld_fan_triangulator
// Welds polygon vertices against a vertex table and emits fan triangles.
// ----------------------------------------------------------------------------
// Each vertex passes through the states in order: IDLE, in which it is
// transferred, CMP, in which every table cell compares its entry with the
// vertex, RED1 and RED2 for the registered tree that turns the match bits
// into an index, and FIN to decide, update the tables and load the output
// register. The next vertex is taken only once FIN has returned to IDLE,
// so one vertex is not taken before the last is through. The sequence does
// not depend on how full the tables are. FIN waits for as long as the
// previous result is held in the output register. A new vertex is taken
// while a result still waits in the output register.
module vertex_weld_fan_triangulator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pos_x, pos_y, pos_z, tex_u, tex_v, texture_id
  input  logic [175:0] s_axis_tdata,
  // double_sided, first_of_polygon
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // weld_idx, vertex_is_new, tri_valid, tri_start, tri_prev, back_valid,
  // face_slot, face_is_new, table_full, zero fill
  output logic [47:0] m_axis_tdata
);

  typedef enum logic [2:0] {IDLE, CMP, RED1, RED2, FIN} state_t;

  localparam int VD = vwft_pkg::VERTEX_DEPTH;
  localparam int FD = vwft_pkg::FACE_DEPTH;
  localparam int GR = vwft_pkg::GROUP;
  localparam int GS = vwft_pkg::GROUPS;

  state_t            state;
  vwft_pkg::key_t    key;
  vwft_pkg::tex_t    tex;
  logic              dbl;
  logic              first;
  vwft_pkg::vfill_t  vfill;
  vwft_pkg::ffill_t  ffill;
  vwft_pkg::vidx_t   poly_start;
  vwft_pkg::vidx_t   poly_prev;
  logic [1:0]        poly_pos;
  vwft_pkg::fidx_t   poly_slot;
  logic              out_valid;
  logic [47:0]       out_data;

  logic [VD-1:0]     vmatch;
  logic [FD-1:0]     fmatch;
  logic [GS-1:0]     grp_hit;
  vwft_pkg::vidx_t   grp_idx [GS];
  logic              vhit;
  vwft_pkg::vidx_t   vidx;
  logic              fhit;
  vwft_pkg::fidx_t   fidx;

  vwft_pkg::vwr_t    vwr;
  vwft_pkg::fwr_t    fwr;

  logic [GS-1:0]     grp_hit_next;
  vwft_pkg::vidx_t   grp_idx_next [GS];
  logic              vhit_next;
  vwft_pkg::vidx_t   vidx_next;
  logic              fhit_next;
  vwft_pkg::fidx_t   fidx_next;

  logic              full;
  logic              face_new;
  logic              vnew;
  vwft_pkg::fidx_t   slot;
  vwft_pkg::vidx_t   idx;
  logic              tri_v;
  logic [1:0]        pos;
  logic              fire;
  logic [47:0]       res;

  genvar gi;
  generate
    for (gi = 0; gi < VD; gi++) begin : g_vcell
      vwft_vcell u_vcell (
        .clk  (clk),
        .index(vwft_pkg::vidx_t'(gi)),
        .fill (vfill),
        .probe(key),
        .wr   (vwr),
        .match(vmatch[gi])
      );
    end
    for (gi = 0; gi < FD; gi++) begin : g_fcell
      vwft_fcell u_fcell (
        .clk  (clk),
        .index(vwft_pkg::fidx_t'(gi)),
        .fill (ffill),
        .probe(tex),
        .wr   (fwr),
        .match(fmatch[gi])
      );
    end
  endgenerate

  always_comb begin
    for (int g = 0; g < GS; g++) begin
      grp_hit_next[g] = 1'b0;
      grp_idx_next[g] = '0;
      for (int j = 0; j < GR; j++) begin
        if (g * GR + j < VD) begin
          if (vmatch[g * GR + j]) begin
            grp_hit_next[g] = 1'b1;
            grp_idx_next[g] = grp_idx_next[g] | vwft_pkg::vidx_t'(g * GR + j);
          end
        end
      end
    end
    vhit_next = 1'b0;
    vidx_next = '0;
    for (int g = 0; g < GS; g++) begin
      vhit_next = vhit_next | grp_hit[g];
      vidx_next = vidx_next | grp_idx[g];
    end
    fhit_next = 1'b0;
    fidx_next = '0;
    for (int f = 0; f < FD; f++) begin
      if (fmatch[f]) begin
        fhit_next = 1'b1;
        fidx_next = fidx_next | vwft_pkg::fidx_t'(f);
      end
    end
  end

  always_comb begin
    full     = 1'b0;
    face_new = 1'b0;
    vnew     = 1'b0;
    slot     = poly_slot;
    idx      = vidx;
    if (first) begin
      if (fhit) begin
        slot = fidx;
      end else if (ffill >= vwft_pkg::ffill_t'(FD)) begin
        full = 1'b1;
      end else begin
        slot     = ffill[vwft_pkg::FW-1:0];
        face_new = 1'b1;
      end
    end
    if (!full && !vhit) begin
      if (vfill >= vwft_pkg::vfill_t'(VD)) begin
        full = 1'b1;
      end else begin
        idx  = vfill[vwft_pkg::VW-1:0];
        vnew = 1'b1;
      end
    end
    pos   = first ? 2'd0 : poly_pos;
    tri_v = (pos == 2'd2);
    fire  = (state == FIN) && (!out_valid || m_axis_tready);
    if (full) begin
      res = 48'd1 << 40;
    end else begin
      res = {7'd0, 1'b0, face_new, 6'(slot), tri_v & dbl,
             tri_v ? 10'(poly_prev) : 10'd0, tri_v ? 10'(poly_start) : 10'd0,
             tri_v, vnew, 10'(idx)};
    end
    vwr.en   = fire && !full && vnew;
    vwr.addr = vfill[vwft_pkg::VW-1:0];
    fwr.en   = fire && !full && face_new;
    fwr.addr = ffill[vwft_pkg::FW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      vfill      <= '0;
      ffill      <= '0;
      poly_start <= '0;
      poly_prev  <= '0;
      poly_pos   <= 2'd0;
      poly_slot  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready && !fire) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_axis_tvalid) begin
            key   <= s_axis_tdata[159:0];
            tex   <= vwft_pkg::tex_t'(s_axis_tdata[175:160]);
            dbl   <= s_axis_tuser[0];
            first <= s_axis_tuser[1];
            state <= CMP;
          end
        end
        CMP: state <= RED1;
        RED1: begin
          grp_hit <= grp_hit_next;
          grp_idx <= grp_idx_next;
          fhit    <= fhit_next;
          fidx    <= fidx_next;
          state   <= RED2;
        end
        RED2: begin
          vhit  <= vhit_next;
          vidx  <= vidx_next;
          state <= FIN;
        end
        FIN: begin
          if (fire) begin
            out_valid <= 1'b1;
            out_data  <= res;
            state     <= IDLE;
            if (!full) begin
              if (face_new) begin
                ffill <= ffill + 1'b1;
              end
              if (vnew) begin
                vfill <= vfill + 1'b1;
              end
              poly_slot <= slot;
              poly_prev <= idx;
              if (pos == 2'd0) begin
                poly_start <= idx;
                poly_pos   <= 2'd1;
              end else begin
                poly_pos <= 2'd2;
              end
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule
